// ===== sv/ils_pkg.sv =====
// Shared types and constants for the indexed list store.
package ils_pkg;

    localparam int LIST_DEPTH_DEF   = 64;
    localparam int ELEMENT_BITS_DEF = 32;

    localparam int KIND_BITS   = 3;
    localparam int POS_BITS    = 6;
    localparam int VALUE_BITS  = 32;
    localparam int LENGTH_BITS = 7;
    localparam int STATUS_BITS = 2;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_PUSH   = 3'd0,
        KIND_INSERT = 3'd1,
        KIND_SET    = 3'd2,
        KIND_GET    = 3'd3,
        KIND_DELETE = 3'd4
    } t_kind;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_INDEX = 2'd2
    } t_status;

    // Per-cycle command broadcast along the cell row.
    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_UP    = 2'd2,
        CMD_DOWN  = 2'd3
    } t_cmd;

endpackage

// ===== sv/ils_cell.sv =====
// One list cell: holds a single element and trades it with its neighbours.
module ils_cell
    import ils_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 7,
    parameter int EW  = ELEMENT_BITS_DEF
) (
    input  logic          i_clk,
    input  t_cmd          i_cmd,
    input  logic [CW-1:0] i_pos,
    input  logic [CW-1:0] i_count,
    input  logic [EW-1:0] i_element,
    input  logic [EW-1:0] i_fill,
    input  logic [EW-1:0] i_left,
    input  logic [EW-1:0] i_right,
    output logic [EW-1:0] o_value
);

    localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
    localparam logic [CW-1:0] NXT_IDX = CW'(IDX + 1);

    logic [EW-1:0] r_value;
    logic [EW-1:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_cmd)
            CMD_WRITE: begin
                if (MY_IDX == i_pos) begin
                    n_value = i_element;
                end else if (MY_IDX >= i_count && MY_IDX < i_pos) begin
                    n_value = i_fill;
                end
            end
            CMD_UP: begin
                if (MY_IDX == i_pos) begin
                    n_value = i_element;
                end else if (MY_IDX > i_pos && MY_IDX <= i_count) begin
                    n_value = i_left;
                end
            end
            CMD_DOWN: begin
                if (MY_IDX >= i_pos && NXT_IDX < i_count) begin
                    n_value = i_right;
                end
            end
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ===== sv/indexed_list_store_top.sv =====
// Indexed list store: bounded ordered list held in a row of shifting cells.
//
// Input channel (i_in_valid / o_in_stall) carries one operation per beat:
// push, insert, set, get or delete, with a position and an element.
// Output channel (o_out_valid / i_out_stall) returns one beat per operation:
// the read value (gets only), the list length after the operation and a
// status (done, full, bad delete index).
// Every cell updates in parallel, so an operation is accepted each cycle unless the
// input stalls, and its result is shown in the next cycle from the output register.
// A stalled result holds; the input stalls only while a result is held
// and the receiver stalls, so one beat is in flight at most.
// The default element is written through i_cfg_we / i_cfg_wdata; the user must write it only while idle (not enforced).
// Reset empties the list, clears the default element and drops o_out_valid.
// Cell contents are not reset; cells beyond the length are never read.
module indexed_list_store_top
    import ils_pkg::*;
#(
    parameter int LIST_DEPTH   = LIST_DEPTH_DEF,
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [VALUE_BITS-1:0]  i_cfg_wdata,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [KIND_BITS-1:0]   i_kind,
    input  logic [POS_BITS-1:0]    i_position,
    input  logic [VALUE_BITS-1:0]  i_element,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [VALUE_BITS-1:0]  o_read_value,
    output logic [LENGTH_BITS-1:0] o_list_length,
    output logic [STATUS_BITS-1:0] o_status
);

    localparam int EW = ELEMENT_BITS;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int IW = $clog2(LIST_DEPTH);
    localparam int XW = (CW > POS_BITS) ? CW + 1 : POS_BITS + 1;
    localparam logic [XW-1:0] DEPTH_X = XW'(LIST_DEPTH);

    logic [EW-1:0]   r_default;
    logic [CW-1:0]   r_count;
    logic            r_out_valid;
    logic [VALUE_BITS-1:0] r_read_value;
    t_status         r_status;

    logic [CW-1:0]   n_count;
    logic [VALUE_BITS-1:0] n_read_value;
    t_status         n_status;
    t_cmd            n_cmd;
    logic [CW-1:0]   n_pos;

    logic            w_accept;
    logic [XW-1:0]   w_pos_x;
    logic [XW-1:0]   w_cnt_x;
    logic [IW-1:0]   w_rd_idx;
    logic [EW-1:0]   w_elem;
    t_cmd            w_cell_cmd;
    logic [EW-1:0]   w_val [LIST_DEPTH];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_pos_x    = XW'(i_position);
    assign w_cnt_x    = XW'(r_count);
    assign w_rd_idx   = IW'(i_position);
    assign w_elem     = EW'(i_element);
    assign w_cell_cmd = w_accept ? n_cmd : CMD_NONE;

    always_comb begin
        n_count      = r_count;
        n_read_value = '0;
        n_status     = ST_DONE;
        n_cmd        = CMD_NONE;
        n_pos        = CW'(w_pos_x);
        case (t_kind'(i_kind))
            KIND_PUSH: begin
                if (w_cnt_x >= DEPTH_X) begin
                    n_status = ST_FULL;
                end else begin
                    n_cmd   = CMD_WRITE;
                    n_pos   = r_count;
                    n_count = CW'(r_count + 1'b1);
                end
            end
            KIND_INSERT, KIND_SET: begin
                if (t_kind'(i_kind) == KIND_INSERT && w_pos_x < w_cnt_x) begin
                    if (w_cnt_x >= DEPTH_X) begin
                        n_status = ST_FULL;
                    end else begin
                        n_cmd   = CMD_UP;
                        n_count = CW'(r_count + 1'b1);
                    end
                end else if (w_pos_x >= DEPTH_X) begin
                    n_status = ST_FULL;
                end else begin
                    n_cmd = CMD_WRITE;
                    if (w_pos_x >= w_cnt_x) begin
                        n_count = CW'(w_pos_x + 1'b1);
                    end
                end
            end
            KIND_GET: begin
                if (w_pos_x < w_cnt_x) begin
                    n_read_value = VALUE_BITS'(w_val[w_rd_idx]);
                end else begin
                    n_read_value = VALUE_BITS'(r_default);
                end
            end
            KIND_DELETE: begin
                if (w_pos_x >= w_cnt_x) begin
                    n_status = ST_BAD_INDEX;
                end else begin
                    n_cmd   = CMD_DOWN;
                    n_count = CW'(r_count - 1'b1);
                end
            end
            default: n_status = ST_DONE;
        endcase
    end

    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        logic [EW-1:0] w_left;
        logic [EW-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_val[g-1];
        end
        if (g == LIST_DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_val[g+1];
        end
        ils_cell #(
            .IDX (g),
            .CW  (CW),
            .EW  (EW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_cmd     (w_cell_cmd),
            .i_pos     (n_pos),
            .i_count   (r_count),
            .i_element (w_elem),
            .i_fill    (r_default),
            .i_left    (w_left),
            .i_right   (w_right),
            .o_value   (w_val[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default   <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_status    <= ST_DONE;
        end else begin
            if (i_cfg_we) begin
                r_default <= EW'(i_cfg_wdata);
            end
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
                r_status    <= n_status;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_value <= n_read_value;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_read_value;
    assign o_list_length = LENGTH_BITS'(r_count);
    assign o_status      = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(LIST_DEPTH))
        else $error("list length beyond capacity");

    a_full_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && n_status == ST_FULL) |=> $stable(r_count))
        else $error("rejected operation changed the length");

    a_delete_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && n_cmd == CMD_DOWN) |=> (r_count == CW'($past(r_count) - 1'b1)))
        else $error("delete did not shorten the list");

    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_out_valid)
        else $error("input stalled with no result held");

endmodule

// ===== sim/indexed_list_store_top_tb.sv =====
// Self-checking testbench for the indexed list store: directed and random beats, back-pressure.
module indexed_list_store_top_tb;
    import ils_pkg::*;

    localparam int CYCLE_LIMIT      = 200_000;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int PHASE_ITEMS      = 55;
    localparam int PHASE_COUNT      = 8;
    localparam logic [POS_BITS-1:0]  POS_MAX = '1;
    localparam logic [KIND_BITS-1:0] KIND_FIRST_UNUSED = 3'd5;

    typedef struct {
        logic [VALUE_BITS-1:0]  read_value;
        logic [LENGTH_BITS-1:0] list_length;
        t_status                status;
    } t_list_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [VALUE_BITS-1:0]  i_cfg_wdata = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic [KIND_BITS-1:0]   i_kind = '0;
    logic [POS_BITS-1:0]    i_position = '0;
    logic [VALUE_BITS-1:0]  i_element = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [VALUE_BITS-1:0]  o_read_value;
    logic [LENGTH_BITS-1:0] o_list_length;
    logic [STATUS_BITS-1:0] o_status;

    // Mirror of the list contents and the default element
    logic [VALUE_BITS-1:0] list_cells [LIST_DEPTH_DEF];
    int unsigned           list_len = 0;
    logic [VALUE_BITS-1:0] fill_value = '0;

    t_list_result results_due [$];

    bit gaps_on = 1'b1;
    bit stalls_on = 1'b1;
    bit hold_request = 1'b0;
    int hold_count;
    int error_count = 0;
    int cycle_count = 0;
    int ops_sent = 0;
    int results_checked = 0;
    int full_refusals = 0;
    int bad_deletes = 0;
    int default_writes = 0;

    indexed_list_store_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_position    (i_position),
        .i_element     (i_element),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_read_value  (o_read_value),
        .o_list_length (o_list_length),
        .o_status      (o_status)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_status place_element(int unsigned pos, logic [VALUE_BITS-1:0] elem);
        if (pos >= LIST_DEPTH_DEF) begin
            return ST_FULL;
        end
        if (pos >= list_len) begin
            for (int unsigned i = list_len; i < pos; i++) list_cells[i] = fill_value;
            list_len = pos + 1;
        end
        list_cells[pos] = elem;
        return ST_DONE;
    endfunction

    function automatic t_list_result apply_op(logic [KIND_BITS-1:0] kind,
                                              logic [POS_BITS-1:0] position,
                                              logic [VALUE_BITS-1:0] elem);
        t_list_result res;
        int unsigned pos;
        pos = position;
        res.read_value = '0;
        res.status = ST_DONE;
        case (kind)
            KIND_PUSH: begin
                if (list_len >= LIST_DEPTH_DEF) begin
                    res.status = ST_FULL;
                end else begin
                    list_cells[list_len] = elem;
                    list_len++;
                end
            end
            KIND_INSERT: begin
                if (pos >= list_len) begin
                    res.status = place_element(pos, elem);
                end else if (list_len >= LIST_DEPTH_DEF) begin
                    res.status = ST_FULL;
                end else begin
                    for (int unsigned i = list_len; i > pos; i--) list_cells[i] = list_cells[i-1];
                    list_cells[pos] = elem;
                    list_len++;
                end
            end
            KIND_SET: res.status = place_element(pos, elem);
            KIND_GET: res.read_value = (pos < list_len) ? list_cells[pos] : fill_value;
            KIND_DELETE: begin
                if (pos >= list_len) begin
                    res.status = ST_BAD_INDEX;
                end else begin
                    for (int unsigned i = pos; i + 1 < list_len; i++)
                        list_cells[i] = list_cells[i+1];
                    list_len--;
                end
            end
            default: ;
        endcase
        res.list_length = LENGTH_BITS'(list_len);
        if (res.status == ST_FULL) full_refusals++;
        if (res.status == ST_BAD_INDEX) bad_deletes++;
        return res;
    endfunction

    // Result beats are judged at the falling edge, where valid and stall are settled
    always @(negedge i_clk) begin : result_check
        t_list_result due;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (results_due.size() == 0) begin
                $error("unexpected result beat: read_value %h list_length %0d status %0d",
                       o_read_value, o_list_length, o_status);
                error_count++;
            end else begin
                due = results_due.pop_front();
                results_checked++;
                if (o_read_value !== due.read_value) begin
                    $error("read_value: expected %h, got %h", due.read_value, o_read_value);
                    error_count++;
                end
                if (o_list_length !== due.list_length) begin
                    $error("list_length: expected %0d, got %0d", due.list_length, o_list_length);
                    error_count++;
                end
                if (o_status !== due.status) begin
                    $error("status: expected %0d, got %0d", due.status, o_status);
                    error_count++;
                end
            end
        end
    end

    initial begin : receiver
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                for (hold_count = 0; hold_count < LONG_HOLD_CYCLES; hold_count++)
                    @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (stalls_on && $urandom_range(0, 6) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_op(logic [KIND_BITS-1:0] kind, logic [POS_BITS-1:0] pos,
                           logic [VALUE_BITS-1:0] elem);
        bit took;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_position <= pos;
        i_element  <= elem;
        do begin
            @(negedge i_clk);
            took = !o_in_stall;
            @(posedge i_clk);
        end while (!took);
        results_due.push_back(apply_op(kind, pos, elem));
        ops_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_default(logic [VALUE_BITS-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        fill_value = value;
        default_writes++;
    endtask

    task automatic send_random_op(int unsigned del_pct);
        logic [KIND_BITS-1:0]  kind;
        logic [POS_BITS-1:0]   pos;
        logic [VALUE_BITS-1:0] elem;
        int unsigned r;
        int unsigned hi;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            kind = KIND_BITS'(KIND_FIRST_UNUSED + $urandom_range(0, 2));
        end else if (r < 4 + del_pct) begin
            kind = KIND_DELETE;
        end else begin
            case ($urandom_range(0, 4))
                0, 1: kind = KIND_PUSH;
                2: kind = KIND_INSERT;
                3: kind = KIND_SET;
                default: kind = KIND_GET;
            endcase
        end
        hi = (list_len > POS_MAX) ? POS_MAX : list_len;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            pos = POS_BITS'($urandom_range(0, hi));
        end else if (r < 75) begin
            r = hi + $urandom_range(0, 4);
            pos = POS_BITS'((r > POS_MAX) ? POS_MAX : r);
        end else begin
            pos = POS_BITS'($urandom_range(0, POS_MAX));
        end
        r = $urandom_range(0, 9);
        elem = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;
        send_op(kind, pos, elem);
    endtask

    task automatic test_empty_list();
        send_op(KIND_GET, '0, '0);
        send_op(KIND_GET, POS_MAX, '1);
        send_op(KIND_DELETE, '0, '0);
        wait_drained();
    endtask

    task automatic test_edits();
        write_default(32'hA5A5_0F0F);
        send_op(KIND_PUSH, '0, '0);
        send_op(KIND_PUSH, POS_MAX, '1);
        send_op(KIND_INSERT, '0, 32'h1234_5678);
        send_op(KIND_INSERT, POS_BITS'(2), 32'h0BAD_F00D);
        send_op(KIND_INSERT, POS_BITS'(4), 32'h4444_0004);  // at the end: behaves as set
        send_op(KIND_SET, POS_BITS'(9), 32'h9999_0009);     // gap takes the default
        send_op(KIND_GET, POS_BITS'(6), '0);
        send_op(KIND_GET, POS_BITS'(9), '0);
        send_op(KIND_GET, POS_BITS'(40), '0);
        send_op(KIND_DELETE, '0, '0);
        send_op(KIND_DELETE, POS_BITS'(3), '0);
        send_op(KIND_DELETE, POS_BITS'(9), '0);
        wait_drained();
    endtask

    task automatic test_full_list();
        send_op(KIND_SET, POS_MAX, 32'hC0DE_003F);
        send_op(KIND_PUSH, '0, 32'h0000_0001);
        send_op(KIND_INSERT, POS_BITS'(5), 32'h0000_0002);
        send_op(KIND_INSERT, POS_MAX, 32'h0000_0003);
        send_op(KIND_SET, POS_MAX, 32'h0000_0004);
        send_op(KIND_GET, POS_MAX, '0);
        send_op(KIND_DELETE, POS_MAX, '0);
        wait_drained();
    endtask

    task automatic test_unused_kinds();
        for (int k = KIND_FIRST_UNUSED; k < (1 << KIND_BITS); k++) begin
            send_op(KIND_BITS'(k), POS_BITS'($urandom), $urandom);
        end
        wait_drained();
    endtask

    // Phases lean towards growing or shrinking so the list swings between empty and full
    task automatic test_random_phases();
        int unsigned del_pct [PHASE_COUNT] = '{8, 25, 60, 60, 8, 8, 60, 35};
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: write_default('1);
                3: write_default('0);
                default: write_default($urandom);
            endcase
            repeat (PHASE_ITEMS) send_random_op(del_pct[p]);
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        gaps_on = 1'b0;
        hold_request = 1'b1;
        repeat (16) send_random_op(25);
        wait_drained();
        gaps_on = 1'b1;
    endtask

    task automatic test_steady_stream();
        write_default($urandom);
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        repeat (60) send_random_op(30);
        wait_drained();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_list();
        test_edits();
        test_full_list();
        test_unused_kinds();
        test_random_phases();
        test_backpressure();
        test_steady_stream();
        $display("Operations sent: %0d, result beats checked: %0d, default writes: %0d",
                 ops_sent, results_checked, default_writes);
        $display("Refused on a full list: %0d, deletes at an invalid index: %0d",
                 full_refusals, bad_deletes);
        if (error_count == 0 && results_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/ils_pkg.sv
sv/ils_cell.sv
sv/indexed_list_store_top.sv
sim/indexed_list_store_top_tb.sv
